@@ rtl/tlq_pkg.sv @@
package tlq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_DRAIN       = 16;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_PUSH   = 2'd0;
	localparam func_t FUNC_PUMP   = 2'd1;
	localparam func_t FUNC_REBASE = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the input item
		logic push;       // ordered insert of the captured level
		logic rebase;     // saturating subtract on every entry
		logic pop;        // drain the head entry into the output register
		logic emit_held;  // output register gets the held level
		logic last;       // last_result of the item being emitted
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t func;
		logic  due_head;  // head entry is due for the captured pump time
		logic  due_next;  // second entry is due as well
		logic  out_free;  // output register can take an item this cycle
	} sts_t;

endpackage

@@ rtl/tlq_ctrl.sv @@
module tlq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tlq_pkg::sts_t sts,
	output tlq_pkg::cmd_t cmd
);
	import tlq_pkg::*;

	localparam int DRN_W = $clog2(MAX_DRAIN);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t           state_q;
	logic [DRN_W-1:0] drn_q;
	logic             in_ready_q;
	logic             more;

	assign in_ready = in_ready_q;

	// another entry follows the head inside the drain limit
	assign more = sts.due_next && (drn_q != DRN_W'(MAX_DRAIN - 1));

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_RUN: begin
				if (sts.out_free) begin
					cmd.last = 1'b1;
					if (sts.func == FUNC_PUMP && sts.due_head) begin
						cmd.pop  = 1'b1;
						cmd.last = !more;
					end else begin
						cmd.emit_held = 1'b1;
						cmd.push      = (sts.func == FUNC_PUSH);
						cmd.rebase    = (sts.func == FUNC_REBASE);
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			drn_q      <= '0;
			in_ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					drn_q <= '0;
					if (in_valid && in_ready_q) begin
						state_q    <= ST_RUN;
						in_ready_q <= 1'b0;
					end else begin
						in_ready_q <= 1'b1;
					end
				end
				ST_RUN: begin
					if (cmd.pop) begin
						drn_q <= drn_q + 1'b1;
					end
					if ((cmd.pop || cmd.emit_held) && cmd.last) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ rtl/tlq_dp.sv @@
module tlq_dp #(
	parameter int QUEUE_DEPTH = tlq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tlq_pkg::cmd_t cmd,
	output tlq_pkg::sts_t sts,
	input  logic [1:0]    func,
	input  logic [31:0]   time_value,
	input  logic [7:0]    level,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    applied_level,
	output logic          applied,
	output logic          target,
	output logic          status,
	output logic          last_result
);
	import tlq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// captured item
	func_t       func_q;
	logic [31:0] time_q;
	logic [7:0]  level_q;

	// queue entries, kept sorted by offset, head at index 0
	logic [31:0] off_q [QUEUE_DEPTH];
	logic [7:0]  lvl_q [QUEUE_DEPTH];
	logic [31:0] off_n [QUEUE_DEPTH];
	logic [7:0]  lvl_n [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] gt;
	logic [QUEUE_DEPTH-1:0] ins;

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       held_q;
	logic             mode_q;
	logic             full;

	logic       out_valid_q;
	logic [7:0] out_level_q;
	logic       out_applied_q;
	logic       out_status_q;
	logic       out_last_q;

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));

	assign sts.func     = func_q;
	assign sts.due_head = (cnt_q != '0) && (off_q[0] <= time_q);
	assign sts.due_next = (cnt_q > CNT_W'(1)) && (off_q[1] <= time_q);
	assign sts.out_free = !out_valid_q || out_ready;

	// entries later than the new offset move up one place
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			gt[i] = (CNT_W'(i) < cnt_q) && (off_q[i] > time_q);
		end
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ins[i] = ((i == 0) ? 1'b1 : !gt[(i == 0) ? 0 : i - 1])
				&& (gt[i] || (CNT_W'(i) == cnt_q));
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			off_n[i] = off_q[i];
			lvl_n[i] = lvl_q[i];
			if (cmd.push && !full) begin
				if (i > 0 && gt[(i == 0) ? 0 : i - 1]) begin
					off_n[i] = off_q[(i == 0) ? 0 : i - 1];
					lvl_n[i] = lvl_q[(i == 0) ? 0 : i - 1];
				end else if (ins[i]) begin
					off_n[i] = time_q;
					lvl_n[i] = level_q;
				end
			end else if (cmd.pop) begin
				if (i < QUEUE_DEPTH - 1) begin
					off_n[i] = off_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
					lvl_n[i] = lvl_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
				end
			end else if (cmd.rebase) begin
				off_n[i] = (off_q[i] > time_q) ? off_q[i] - time_q : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			off_q[i] <= off_n[i];
			lvl_q[i] <= lvl_n[i];
		end
		if (cmd.load) begin
			func_q  <= func;
			time_q  <= time_value;
			level_q <= level;
		end
		if (cmd.pop) begin
			out_level_q   <= lvl_q[0];
			out_applied_q <= 1'b1;
			out_status_q  <= 1'b0;
			out_last_q    <= cmd.last;
		end else if (cmd.emit_held) begin
			out_level_q   <= held_q;
			out_applied_q <= 1'b0;
			out_status_q  <= cmd.push && full;
			out_last_q    <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			held_q      <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.push && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.pop) begin
				cnt_q  <= cnt_q - 1'b1;
				held_q <= lvl_q[0];
			end
			if (cmd.pop || cmd.emit_held) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign applied_level = out_level_q;
	assign applied       = out_applied_q;
	assign target        = mode_q;
	assign status        = out_status_q;
	assign last_result   = out_last_q;

endmodule

@@ rtl/timestamped_level_event_queue_core.sv @@
// the item is captured on accept; its first result is loaded into the output register once that register is free
// push, rebase and idle pump give one result each; a pump drains up to MAX_DRAIN due entries,
//   one entry per cycle while the output register is free, through the head shift of the entry row
// the output register lets a finished item wait while the next one is accepted
// reset: arst_n asynchronous, clears entry count, held level, routing mode and valids
module timestamped_level_event_queue_core #(
	parameter int QUEUE_DEPTH = tlq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] time_value,
	input  logic [7:0]  level,
	input  logic        last_of_feed,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  applied_level,
	output logic        applied,
	output logic        target,
	output logic        status,
	output logic        last_result,
	// routing mode register
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import tlq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// last_of_feed only marks feed boundaries for the sender; no logic depends on it

	// sequencer: accept, then one step per cycle while the output register is free
	tlq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// sorted entry row with parallel compare per entry, held level, output register
	tlq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.time_value    (time_value),
		.level         (level),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.applied_level (applied_level),
		.applied       (applied),
		.target        (target),
		.status        (status),
		.last_result   (last_result)
	);

endmodule

@@ tb/timestamped_level_event_queue_core_tb.sv @@
`timescale 1ns / 1ps

module timestamped_level_event_queue_core_tb;
	import tlq_pkg::*;

	localparam int    DEPTH        = QUEUE_DEPTH_DEF;
	// code 3 has no name in the package; the block treats it as a no-op
	localparam func_t FUNC_UNUSED  = 2'd3;
	// cycles with no handshake on either side before the run is declared hung
	localparam int    QUIET_LIMIT  = 4000;
	localparam int    REPORT_LIMIT = 10;

	// one result item as seen on the output port
	typedef struct packed {
		logic [7:0] lvl;
		logic       app;
		logic       tgt;
		logic       st;
		logic       last;
	} level_result_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	func_t       func         = FUNC_PUSH;
	logic [31:0] time_value   = '0;
	logic [7:0]  level        = '0;
	logic        last_of_feed = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [7:0]  applied_level;
	logic        applied;
	logic        target;
	logic        status;
	logic        last_result;
	logic        cfg_we       = 1'b0;
	logic        cfg_wdata    = 1'b0;

	// shadow of the queue contents, kept in offset order like the block
	logic [31:0]   stamp_q[$];
	logic [7:0]    level_q[$];
	logic [7:0]    last_drained   = '0;
	logic          route_handheld = 1'b0;
	// results still owed by the block, oldest first
	level_result_t owed_results[$];

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	timestamped_level_event_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.time_value   (time_value),
		.level        (level),
		.last_of_feed (last_of_feed),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.applied_level(applied_level),
		.applied      (applied),
		.target       (target),
		.status       (status),
		.last_result  (last_result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	function automatic void owe_result(logic [7:0] lvl, logic app, logic st, logic last);
		owed_results.insert(owed_results.size(),
			'{lvl: lvl, app: app, tgt: route_handheld, st: st, last: last});
	endfunction

	// updates the shadow queue for one accepted item and queues its results
	function automatic void predict_item(func_t f, logic [31:0] tv, logic [7:0] lv);
		int pos;
		int n;
		case (f)
			FUNC_PUSH: begin
				if (stamp_q.size() >= DEPTH) begin
					// full: level is dropped, queue untouched
					owe_result(last_drained, 1'b0, 1'b1, 1'b1);
				end else begin
					// insert after every entry with an equal or smaller offset
					pos = stamp_q.size();
					while (pos > 0 && stamp_q[pos - 1] > tv)
						pos--;
					stamp_q.insert(pos, tv);
					level_q.insert(pos, lv);
					owe_result(last_drained, 1'b0, 1'b0, 1'b1);
				end
			end
			FUNC_PUMP: begin
				n = 0;
				while (n < MAX_DRAIN && n < stamp_q.size() && stamp_q[n] <= tv)
					n++;
				if (n == 0)
					owe_result(last_drained, 1'b0, 1'b0, 1'b1);
				for (int i = 0; i < n; i++) begin
					last_drained = level_q[0];
					level_q.delete(0);
					stamp_q.delete(0);
					owe_result(last_drained, 1'b1, 1'b0, i == n - 1);
				end
			end
			FUNC_REBASE: begin
				// saturating subtract of the time value
				foreach (stamp_q[i])
					stamp_q[i] = (stamp_q[i] > tv) ? stamp_q[i] - tv : 32'd0;
				owe_result(last_drained, 1'b0, 1'b0, 1'b1);
			end
			default: begin
				owe_result(last_drained, 1'b0, 1'b0, 1'b1);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// result side: random stalls and the compare against owed results
	// ---------------------------------------------------------------

	always @(posedge clk) begin : result_check
		level_result_t got;
		level_result_t want;
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			got = '{lvl: applied_level, app: applied, tgt: target, st: status,
				last: last_result};
			if (owed_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t unexpected result: lvl %02h app %0b tgt %0b st %0b last %0b",
						$realtime, got.lvl, got.app, got.tgt, got.st, got.last);
			end else begin
				want = owed_results[0];
				owed_results.delete(0);
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t mismatch: expected lvl %02h app %0b tgt %0b st %0b last %0b",
							$realtime, want.lvl, want.app, want.tgt, want.st, want.last);
						$display("%0t           got      lvl %02h app %0b tgt %0b st %0b last %0b",
							$realtime, got.lvl, got.app, got.tgt, got.st, got.last);
					end
				end
			end
		end
	end

	// hang detection: counts cycles in which neither side moves an item
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[timestamped_level_event_queue_core] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------

	// presents one item after a random gap and returns in the step it is taken;
	// valid stays high so a following call can present the next item at once
	task automatic send_item(func_t f, logic [31:0] tv, logic [7:0] lv, logic lof);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		time_value   <= tv;
		level        <= lv;
		last_of_feed <= lof;
		do
			@(posedge clk);
		while (!in_ready);
		predict_item(f, tv, lv);
	endtask

	// stop sending and wait until every owed result has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		// spare cycles before the caller goes on
		repeat (4) @(posedge clk);
	endtask

	// routing mode is only changed with the block idle
	task automatic write_routing(logic handheld);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= handheld;
		@(posedge clk);
		cfg_we         <= 1'b0;
		route_handheld  = handheld;
	endtask

	function automatic logic [31:0] random_offset();
		case ($urandom_range(9))
			0:       return $urandom;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'd0;
			default: return $urandom_range(200);
		endcase
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// nothing stored yet: pump, rebase and the unused code all return the held level
	task automatic test_empty_queue();
		send_item(FUNC_PUMP, 32'hFFFF_FFFF, 8'h00, 1'b0);
		send_item(FUNC_REBASE, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1);
	endtask

	// offset order with equal offsets kept in arrival order, extremes of both fields
	task automatic test_ordered_insert();
		send_item(FUNC_PUSH, 32'd100, 8'h00, 1'b0);
		send_item(FUNC_PUSH, 32'd0, 8'hFF, 1'b0);
		send_item(FUNC_PUSH, 32'd100, 8'h5A, 1'b0);
		send_item(FUNC_PUSH, 32'hFFFF_FFFF, 8'hA5, 1'b0);
		send_item(FUNC_PUSH, 32'd50, 8'h01, 1'b0);
		send_item(FUNC_PUSH, 32'd100, 8'h80, 1'b0);
		send_item(FUNC_PUSH, 32'd0, 8'h7F, 1'b1);
		// partial drain stops at the first entry that is not yet due
		send_item(FUNC_PUMP, 32'd99, 8'h00, 1'b0);
		// nothing due now
		send_item(FUNC_PUMP, 32'd0, 8'h00, 1'b0);
	endtask

	// rebase below the stored offsets, then past the smaller ones so they clamp at zero
	task automatic test_rebase_saturation();
		send_item(FUNC_REBASE, 32'd60, 8'h00, 1'b0);
		send_item(FUNC_REBASE, 32'd41, 8'h00, 1'b0);
	endtask

	// fill to depth, drop one push, then drain the whole queue in a single pump
	task automatic test_full_queue();
		write_routing(1'b1);
		for (int i = 0; i < DEPTH - 4; i++)
			send_item(FUNC_PUSH, (i % 3 == 0) ? 32'd0 : $urandom_range(1000),
				8'($urandom_range(255)), i == DEPTH - 5);
		send_item(FUNC_PUSH, 32'd0, 8'hC3, 1'b1);
		send_item(FUNC_REBASE, 32'hFFFF_FFFF, 8'h00, 1'b0);
		send_item(FUNC_PUMP, 32'd0, 8'h00, 1'b0);
	endtask

	// mostly feeds: a burst of pushes closed by a pump, with rebases and
	// stray pumps between them; now and then a burst long enough to overflow
	task automatic test_random_traffic(int n_items);
		int sent;
		int burst;
		int pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				burst = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
				for (int i = 0; i < burst; i++)
					send_item(FUNC_PUSH, random_offset(), 8'($urandom_range(255)),
						i == burst - 1);
				send_item(FUNC_PUMP, random_offset(), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				sent += burst + 1;
			end else if (pick < 85) begin
				send_item(FUNC_REBASE,
					($urandom_range(3) == 0) ? $urandom : $urandom_range(60),
					8'($urandom_range(255)), 1'($urandom_range(1)));
				sent++;
			end else if (pick < 97) begin
				send_item(FUNC_PUMP, random_offset(), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				sent++;
			end else begin
				send_item(FUNC_UNUSED, $urandom, 8'($urandom_range(255)),
					1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// sequence of the run
	// ---------------------------------------------------------------

	initial begin
		// sender idles often, receiver stalls more often still
		send_gap_pct   = 38;
		recv_stall_pct = 65;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_ordered_insert();
		test_rebase_saturation();
		test_full_queue();

		write_routing(1'b0);
		test_random_traffic(80);

		// swap the idling of the two sides
		write_routing(1'b1);
		send_gap_pct   = 65;
		recv_stall_pct = 38;
		test_random_traffic(80);

		// full rate on both sides
		write_routing(1'b0);
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_random_traffic(80);

		settle();
		repeat (10) @(posedge clk);
		if (owed_results.size() != 0)
			mismatch_count++;

		if (mismatch_count == 0)
			$display("[timestamped_level_event_queue_core] OK");
		else
			$display("[timestamped_level_event_queue_core] ERROR");
		$finish;
	end

endmodule
